>>> rtl/ccnb_pkg.sv
// Shared types and constants for the binary-XML integer element encoder.
`default_nettype none

package ccnb_pkg;

	// Marker bit that ends a header
	localparam logic [7:0] HDR_MARK = 8'h80;

	// Default type code of the blob header
	localparam logic [2:0] BLOB_TYPE_DEF = 3'd5;

	// Largest payload length in bytes
	localparam logic [2:0] MAX_BYTES = 3'd4;

	// Input word: one element to encode
	typedef struct packed {
		logic [31:0] tag_number;
		logic [2:0]  type_code;
		logic [31:0] value;
		logic [2:0]  byte_count;
	} in_word_t;

	// Output word: one byte of the element
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_word_t;

	// Serializer phases
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAG_GRP,
		ST_TAG_END,
		ST_BLOB_HDR,
		ST_PAYLOAD,
		ST_TERM
	} state_t;

	// Load values prepared from an input word
	typedef struct packed {
		logic [27:0] tag_sr;
		logic [2:0]  groups;
		logic [7:0]  tag_hdr;
		logic [31:0] val_sr;
		logic [2:0]  cnt;
	} prep_t;

endpackage

`default_nettype wire

>>> rtl/ccnb_prep.sv
// Load-time preparation: tag group count, aligned shift words and payload length.
`default_nettype none

module ccnb_prep (
	input  var ccnb_pkg::in_word_t word,
	output var ccnb_pkg::prep_t    prep
);

	logic [27:0] tag_rest;
	logic [2:0]  groups;
	logic [2:0]  cnt;
	logic [27:0] tag_sr;
	logic [31:0] val_sr;
	logic [7:0]  tag_hdr;

	assign tag_rest = word.tag_number[31:4];

	// Count the 7-bit groups needed for the upper tag bits
	always_comb begin
		if (|tag_rest[27:21]) begin
			groups = 3'd4;
		end else if (|tag_rest[20:14]) begin
			groups = 3'd3;
		end else if (|tag_rest[13:7]) begin
			groups = 3'd2;
		end else if (|tag_rest[6:0]) begin
			groups = 3'd1;
		end else begin
			groups = 3'd0;
		end
	end

	// Align the first group to the top of the tag shift word
	always_comb begin
		case (groups)
			3'd4:    tag_sr = tag_rest;
			3'd3:    tag_sr = {tag_rest[20:0], 7'd0};
			3'd2:    tag_sr = {tag_rest[13:0], 14'd0};
			3'd1:    tag_sr = {tag_rest[6:0], 21'd0};
			default: tag_sr = '0;
		endcase
	end

	// Saturate the byte count, or pick the shortest length that holds the value
	always_comb begin
		if (word.byte_count > ccnb_pkg::MAX_BYTES) begin
			cnt = ccnb_pkg::MAX_BYTES;
		end else if (word.byte_count != 3'd0) begin
			cnt = word.byte_count;
		end else if (|word.value[31:24]) begin
			cnt = 3'd4;
		end else if (|word.value[23:16]) begin
			cnt = 3'd3;
		end else if (|word.value[15:8]) begin
			cnt = 3'd2;
		end else begin
			cnt = 3'd1;
		end
	end

	// Align the first payload byte to the top of the value shift word
	always_comb begin
		case (cnt)
			3'd1:    val_sr = {word.value[7:0], 24'd0};
			3'd2:    val_sr = {word.value[15:0], 16'd0};
			3'd3:    val_sr = {word.value[23:0], 8'd0};
			default: val_sr = word.value;
		endcase
	end

	assign tag_hdr = ccnb_pkg::HDR_MARK | {1'b0, word.tag_number[3:0], word.type_code};

	assign prep = '{tag_sr: tag_sr, groups: groups, tag_hdr: tag_hdr,
	                val_sr: val_sr, cnt: cnt};

endmodule

`default_nettype wire

>>> rtl/ccnb_binary_int_encoder_unit.sv
// Top level of the binary-XML integer element encoder: sequencer, shift registers, output register.
// Each accepted word becomes one element sent as one byte per output word: the tag groups, the
// tag header byte, the blob header byte, the payload bytes most significant first, and a
// terminating zero byte flagged by last. An element is 4 to 11 bytes long; the single output
// byte register moves one byte per cycle when the output side does not stall, and the tag and
// value shift registers step one 7-bit group or one byte per tag group or payload byte sent.
// The next input word is taken in the cycle the terminating byte is loaded, so elements follow
// each other without a gap. BLOB_TYPE sets the type code of the blob header.
`default_nettype none

module ccnb_binary_int_encoder_unit #(
	parameter logic [2:0] BLOB_TYPE = ccnb_pkg::BLOB_TYPE_DEF
) (
	input  var logic                 clk,
	input  var logic                 arst_n,
	input  var logic                 src_valid,
	output var logic                 src_stall,
	input  var ccnb_pkg::in_word_t   src_data,
	output var logic                 enc_valid,
	input  var logic                 enc_stall,
	output var ccnb_pkg::out_word_t  enc_data
);

	ccnb_pkg::state_t    state_q;
	ccnb_pkg::state_t    state_nxt;
	ccnb_pkg::prep_t     prep;
	ccnb_pkg::out_word_t byte_nxt;

	logic [27:0] tag_sr_q;
	logic [2:0]  grp_q;
	logic [7:0]  tag_hdr_q;
	logic [31:0] val_sr_q;
	logic [2:0]  cnt_q;
	logic        out_valid_q;
	ccnb_pkg::out_word_t out_q;

	logic adv;
	logic emit;
	logic accept;

	ccnb_prep u_prep (
		.word (src_data),
		.prep (prep)
	);

	// Output register can take a new byte when empty or being drained
	assign adv    = !out_valid_q || !enc_stall;
	assign accept = src_valid && !src_stall;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ccnb_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = (prep.groups != 3'd0) ? ccnb_pkg::ST_TAG_GRP
					                                  : ccnb_pkg::ST_TAG_END;
				end
			end
			ccnb_pkg::ST_TAG_GRP: begin
				if (adv && grp_q == 3'd1) begin
					state_nxt = ccnb_pkg::ST_TAG_END;
				end
			end
			ccnb_pkg::ST_TAG_END: begin
				if (adv) begin
					state_nxt = ccnb_pkg::ST_BLOB_HDR;
				end
			end
			ccnb_pkg::ST_BLOB_HDR: begin
				if (adv) begin
					state_nxt = ccnb_pkg::ST_PAYLOAD;
				end
			end
			ccnb_pkg::ST_PAYLOAD: begin
				if (adv && cnt_q == 3'd1) begin
					state_nxt = ccnb_pkg::ST_TERM;
				end
			end
			ccnb_pkg::ST_TERM: begin
				if (adv) begin
					if (accept) begin
						state_nxt = (prep.groups != 3'd0) ? ccnb_pkg::ST_TAG_GRP
						                                  : ccnb_pkg::ST_TAG_END;
					end else begin
						state_nxt = ccnb_pkg::ST_IDLE;
					end
				end
			end
			default: state_nxt = ccnb_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: byte to send and input stall
	always_comb begin
		emit      = 1'b0;
		src_stall = 1'b1;
		byte_nxt  = '0;
		case (state_q)
			ccnb_pkg::ST_IDLE: begin
				src_stall = 1'b0;
			end
			ccnb_pkg::ST_TAG_GRP: begin
				emit              = adv;
				byte_nxt.out_byte = {1'b0, tag_sr_q[27:21]};
			end
			ccnb_pkg::ST_TAG_END: begin
				emit              = adv;
				byte_nxt.out_byte = tag_hdr_q;
			end
			ccnb_pkg::ST_BLOB_HDR: begin
				emit              = adv;
				byte_nxt.out_byte = ccnb_pkg::HDR_MARK | {2'b00, cnt_q, BLOB_TYPE};
			end
			ccnb_pkg::ST_PAYLOAD: begin
				emit              = adv;
				byte_nxt.out_byte = val_sr_q[31:24];
			end
			ccnb_pkg::ST_TERM: begin
				emit          = adv;
				src_stall     = !adv;
				byte_nxt.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccnb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Load the shift registers on accept, step them on each tag group or payload byte sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			grp_q <= prep.groups;
			cnt_q <= prep.cnt;
		end else if (emit && state_q == ccnb_pkg::ST_TAG_GRP) begin
			grp_q <= grp_q - 3'd1;
		end else if (emit && state_q == ccnb_pkg::ST_PAYLOAD) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_sr_q  <= prep.tag_sr;
			tag_hdr_q <= prep.tag_hdr;
			val_sr_q  <= prep.val_sr;
		end else if (emit && state_q == ccnb_pkg::ST_TAG_GRP) begin
			tag_sr_q <= {tag_sr_q[20:0], 7'd0};
		end else if (emit && state_q == ccnb_pkg::ST_PAYLOAD) begin
			val_sr_q <= {val_sr_q[23:0], 8'd0};
		end
	end

	// Output register: fill when a byte is sent, drop valid when drained with nothing new
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= byte_nxt;
		end
	end

	assign enc_valid = out_valid_q;
	assign enc_data  = out_q;

	// Tag group phase always has a group left to send
	a_grp_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ccnb_pkg::ST_TAG_GRP |-> grp_q != 3'd0)
		else $error("tag group phase with no group left");

	// Payload phase always has one to four bytes left
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ccnb_pkg::ST_PAYLOAD |-> (cnt_q != 3'd0 && cnt_q <= ccnb_pkg::MAX_BYTES))
		else $error("payload count out of range");

	// Leaving the terminator phase shows a flagged byte next
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ccnb_pkg::ST_TERM && adv) |=> (enc_valid && enc_data.last))
		else $error("terminator byte not flagged");

	// A flagged byte is always zero
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(enc_valid && enc_data.last) |-> enc_data.out_byte == 8'd0)
		else $error("flagged byte not zero");

	// Input is taken only when the sequencer is free or finishing
	a_accept_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == ccnb_pkg::ST_IDLE || state_q == ccnb_pkg::ST_TERM))
		else $error("input taken mid element");

endmodule

`default_nettype wire

>>> test/tb_ccnb_binary_int_encoder_unit.sv
// Self-checking testbench for the binary-XML integer element encoder, directed and random words.
`default_nettype none

module tb_ccnb_binary_int_encoder_unit;

	localparam logic [2:0] BLOB_CODE = ccnb_pkg::BLOB_TYPE_DEF;
	localparam int QUIET_LIMIT = 500;
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_WORDS = 248;
	localparam int REPORT_MAX = 10;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	ccnb_pkg::in_word_t  src_data = '0;
	logic                enc_valid;
	logic                enc_stall = 1'b0;
	ccnb_pkg::out_word_t enc_data;

	// Bytes of every accepted element still owed by the encoder, oldest first
	ccnb_pkg::out_word_t element_bytes[$];
	int        mismatch_count = 0;
	int        quiet_cycles = 0;
	bit        no_idle = 1'b0;

	ccnb_binary_int_encoder_unit #(
		.BLOB_TYPE(BLOB_CODE)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.enc_valid (enc_valid),
		.enc_stall (enc_stall),
		.enc_data  (enc_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Append one output word to the expected stream
	function automatic void push_byte(input logic [7:0] b, input logic is_last);
		ccnb_pkg::out_word_t w;
		w.out_byte = b;
		w.last = is_last;
		element_bytes.push_back(w);
	endfunction

	// Expand one input word into the bytes of its element
	function automatic void predict_element(input ccnb_pkg::in_word_t w);
		logic [2:0]  cnt;
		logic [27:0] rest;
		logic [31:0] shifted;
		int          groups;
		cnt = (w.byte_count > ccnb_pkg::MAX_BYTES) ? ccnb_pkg::MAX_BYTES : w.byte_count;
		if (cnt == 3'd0) begin
			if (w.value[31:24] != 8'h00)
				cnt = 3'd4;
			else if (w.value[23:16] != 8'h00)
				cnt = 3'd3;
			else if (w.value[15:8] != 8'h00)
				cnt = 3'd2;
			else
				cnt = 3'd1;
		end
		// tag groups, most significant first, only as many as needed
		rest = w.tag_number[31:4];
		groups = 0;
		while (rest != 28'd0) begin
			groups++;
			rest = rest >> 7;
		end
		for (int g = groups; g >= 1; g--) begin
			shifted = w.tag_number >> (4 + 7 * (g - 1));
			push_byte({1'b0, shifted[6:0]}, 1'b0);
		end
		push_byte(ccnb_pkg::HDR_MARK | {1'b0, w.tag_number[3:0], w.type_code}, 1'b0);
		// blob header: length always fits the final byte
		push_byte(ccnb_pkg::HDR_MARK | {1'b0, 1'b0, cnt, BLOB_CODE}, 1'b0);
		for (int i = int'(cnt) - 1; i >= 0; i--) begin
			shifted = w.value >> (8 * i);
			push_byte(shifted[7:0], 1'b0);
		end
		push_byte(8'h00, 1'b1);
	endfunction

	task automatic report_mismatch(input string what, input ccnb_pkg::out_word_t want,
		input ccnb_pkg::out_word_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b",
				$time, what, want.out_byte, want.last, got.out_byte, got.last);
	endtask

	// Send one word, idling now and then, and hold it until accepted
	task automatic send_word(input logic [31:0] tag, input logic [2:0] tt,
		input logic [31:0] val, input logic [2:0] cnt);
		ccnb_pkg::in_word_t w;
		w.tag_number = tag;
		w.type_code = tt;
		w.value = val;
		w.byte_count = cnt;
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= w;
		do @(posedge clk); while (src_stall);
		predict_element(w);
	endtask

	// Drive the output stall at random, none while idling is off
	always @(posedge clk) begin
		enc_stall <= !no_idle && ($urandom_range(0, 99) < 10);
	end

	// Check each accepted output word against the oldest expected byte
	always @(posedge clk) begin : check_output
		ccnb_pkg::out_word_t head;
		if (arst_n && enc_valid && !enc_stall) begin
			if (element_bytes.size() == 0) begin
				head = '0;
				report_mismatch("unexpected word", head, enc_data);
			end else begin
				head = element_bytes.pop_front();
				if (enc_data.out_byte !== head.out_byte || enc_data.last !== head.last)
					report_mismatch("wrong word", head, enc_data);
			end
		end
	end

	// Abort when neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (enc_valid && !enc_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Field extremes, zero value with automatic length, oversized count
	task automatic test_header_extremes();
		send_word(32'h0000_0000, 3'd0, 32'h0000_0000, 3'd0);
		send_word(32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 3'd0);
		send_word(32'hFFFF_FFFF, 3'd6, 32'hFFFF_FFFF, 3'd7);
		send_word(32'h0000_000F, 3'd1, 32'h0000_00FF, 3'd0);
		send_word(32'hFFFF_FFF0, 3'd2, 32'h0000_0000, 3'd4);
	endtask

	// Tag values on either side of each group boundary
	task automatic test_tag_groups();
		send_word(32'h0000_0010, 3'd3, 32'h0000_0001, 3'd0);
		send_word(32'h0000_07FF, 3'd4, 32'h0000_0080, 3'd0);
		send_word(32'h0000_0800, 3'd5, 32'h0000_0100, 3'd0);
		send_word(32'h0003_FFFF, 3'd6, 32'h0000_FFFF, 3'd0);
		send_word(32'h0004_0000, 3'd7, 32'h0001_0000, 3'd0);
		send_word(32'h01FF_FFFF, 3'd0, 32'h00FF_FFFF, 3'd0);
		send_word(32'h0200_0000, 3'd1, 32'h0100_0000, 3'd0);
	endtask

	// Every byte count, including the saturating ones
	task automatic test_byte_counts();
		for (int c = 0; c < 8; c++)
			send_word(32'h0000_1000 + 32'(c), 3'(c), 32'h1234_5678, 3'(c));
		send_word(32'h0000_0005, 3'd2, 32'h0000_0000, 3'd6);
		send_word(32'h0000_0100, 3'd3, 32'h0000_0000, 3'd1);
	endtask

	// Random words with tags and values of every width
	task automatic test_random_words();
		logic [31:0] tag;
		logic [31:0] val;
		int          grp;
		int          nbytes;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_idle = (i >= 100 && i < 180);
			grp = $urandom_range(0, 4);
			tag = $urandom;
			if (grp < 4)
				tag = tag & ((32'h1 << (4 + 7 * grp)) - 32'h1);
			nbytes = $urandom_range(0, 4);
			val = $urandom;
			if (nbytes < 4)
				val = val & ((32'h1 << (8 * nbytes)) - 32'h1);
			send_word(tag, 3'($urandom_range(0, 7)), val, 3'($urandom_range(0, 7)));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_extremes();
		test_tag_groups();
		test_byte_counts();
		test_random_words();
		src_valid <= 1'b0;
		// drain, then give stray words a chance to show up
		while (element_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
